@@ hw/rtl/ifvc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ifvc_pkg
// Shared types and codes for the fragment verdict cache.
// ----------------------------------------------------------------------------
package ifvc_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_TICK     = 3'd5;

  localparam logic [0:0] REG_LIFETIME = 1'd0;
  localparam logic [0:0] REG_LOGMASK  = 1'd1;

  localparam logic [31:0] HASH_MUL      = 32'd127;
  localparam logic [7:0]  LIFETIME_RST  = 8'd120;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ident;
    logic [7:0]  protocol;
    logic [7:0]  tos;
    logic [12:0] frag_offset;
    logic        more_fragments;
    logic [15:0] payload_len;
    logic [31:0] verdict;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] verdict_out;
    logic        last_seen;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] hash;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ipt;
    logic [12:0] frag_offset;
    logic        more_fragments;
    logic [13:0] next_off;
    logic [31:0] verdict;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ipt;
    logic [31:0] verdict;
    logic [13:0] next_off;
    logic [7:0]  ttl;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_EVAL, BK_TREAD, BK_TEVAL, BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/ifvc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ifvc_if
// Valid/ready channels: item, result and configuration write.
// ----------------------------------------------------------------------------
interface ifvc_req_if;
  logic           valid;
  logic           ready;
  ifvc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ifvc_rsp_if;
  logic           valid;
  logic           ready;
  ifvc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ifvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ifvc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ifvc_front
// Accepts items, forms the key and hash and queues a command (depth 2).
// ----------------------------------------------------------------------------
module ifvc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  ifvc_req_if.sink            req,
  output ifvc_pkg::cmd_t      cmd,
  output logic                cmd_valid,
  input  wire logic           cmd_ready
);
  import ifvc_pkg::*;

  cmd_t       q [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  cmd_t       c_new;
  logic [31:0] sum;
  logic       push, pop;

  assign sum = req.data.src_addr + req.data.dst_addr + {16'd0, req.data.ident}
             + {24'd0, req.data.protocol};

  always_comb begin
    c_new.action         = req.data.action;
    c_new.hash           = sum * HASH_MUL;
    c_new.src_addr       = req.data.src_addr;
    c_new.dst_addr       = req.data.dst_addr;
    c_new.ipt            = {req.data.ident, req.data.protocol, req.data.tos};
    c_new.frag_offset    = req.data.frag_offset;
    c_new.more_fragments = req.data.more_fragments;
    c_new.next_off       = {1'b0, req.data.frag_offset} + {1'b0, req.data.payload_len[15:3]};
    c_new.verdict        = req.data.verdict;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/ifvc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ifvc_back
// Set memory, insert/lookup read-modify-write and the aging sweep.
// ----------------------------------------------------------------------------
module ifvc_back #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ifvc_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire logic [7:0]     lifetime,
  input  wire logic [31:0]    log_mask,
  ifvc_rsp_if.source          rsp
);
  import ifvc_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  // one row per set; valid bits live in the rows, cleared by sweep after reset
  entry_t mem [BUCKETS][WAYS];
  entry_t row [WAYS];
  entry_t wrow [WAYS];

  bk_state_t state, state_next;
  logic [BW-1:0] addr, sweep;
  logic          clr_done;
  logic          row_we;
  cmd_t          c;
  rsp_t          r, r_next;
  logic [WAYS-1:0] match, freew;
  logic [WW-1:0]   hit_w, free_w;
  logic            any_hit, any_free;

  generate
    if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
      assign addr = c.hash[BW-1:0];
    end else begin : g_recip
      // exact hash / BUCKETS by reciprocal multiply, registered on accept
      localparam logic [63:0] RECIP = ((64'd1 << (32 + BW)) + 64'(BUCKETS) - 64'd1)
                                      / 64'(BUCKETS);
      logic [64:0] prod;
      logic [31:0] quot;

      assign prod = 65'(cmd.hash) * 65'(RECIP[32:0]);

      always_ff @(posedge clk) begin
        if (cmd_ready && cmd_valid) quot <= 32'(prod >> (32 + BW));
      end

      // only the low bits of hash - quot * BUCKETS are needed for the set
      assign addr = c.hash[BW-1:0] - BW'(quot * 32'(BUCKETS));
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int w = 0; w < WAYS; w++) begin
      if (row_we) mem[(state == BK_TEVAL || !clr_done) ? sweep : addr][w] <= wrow[w];
      row[w] <= mem[(state == BK_TREAD) ? sweep : addr][w];
    end
  end

  always_comb begin
    match = '0; freew = '0; hit_w = '0; free_w = '0; any_hit = 1'b0; any_free = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = row[w].valid && row[w].src == c.src_addr && row[w].dst == c.dst_addr
                 && row[w].ipt == c.ipt;
      freew[w] = !row[w].valid;
      if (match[w]) begin hit_w = WW'(w); any_hit = 1'b1; end
      if (freew[w]) begin free_w = WW'(w); any_free = 1'b1; end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (cmd_valid && clr_done)
                  state_next = (cmd.action == ACT_TICK) ? BK_TREAD : BK_READ;
      BK_READ:  state_next = BK_EVAL;
      BK_EVAL:  state_next = BK_OUT;
      BK_TREAD: state_next = BK_TEVAL;
      BK_TEVAL: state_next = (sweep == BW'(BUCKETS - 1)) ? BK_OUT : BK_TREAD;
      BK_OUT:   if (rsp.ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    wrow   = row;
    row_we = 1'b0;
    r_next = r;
    if (!clr_done) begin
      row_we = 1'b1;
      for (int w = 0; w < WAYS; w++) wrow[w].valid = 1'b0;
    end else begin
      unique case (state)
        BK_EVAL: begin
          r_next = '{status: ST_MISS, verdict_out: 32'd0, last_seen: 1'b0};
          if (c.action == ACT_INSERT) begin
            if (any_hit) r_next.status = ST_PRESENT;
            else if (any_free) begin
              r_next.status = ST_INSERTED;
              row_we = 1'b1;
              wrow[free_w] = '{valid: 1'b1, src: c.src_addr, dst: c.dst_addr, ipt: c.ipt,
                               verdict: c.verdict & ~log_mask, next_off: c.next_off,
                               ttl: lifetime};
            end else r_next.status = ST_FULL;
          end else if (c.action == ACT_LOOKUP && any_hit) begin
            r_next.status      = ST_HIT;
            r_next.verdict_out = row[hit_w].verdict;
            if ({1'b0, c.frag_offset} == row[hit_w].next_off) begin
              row_we = 1'b1;
              if (!c.more_fragments) begin
                wrow[hit_w].ttl = 8'd1;
                r_next.last_seen = 1'b1;
              end else wrow[hit_w].next_off = c.next_off;
            end
          end
        end
        BK_TEVAL: begin
          row_we = 1'b1;
          r_next = '{status: ST_TICK, verdict_out: 32'd0, last_seen: 1'b0};
          for (int w = 0; w < WAYS; w++) begin
            if (row[w].valid) begin
              if (row[w].ttl <= 8'd1) begin
                wrow[w].ttl = 8'd0; wrow[w].valid = 1'b0;
              end else wrow[w].ttl = row[w].ttl - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd_ready = (state == BK_IDLE) && clr_done;
  assign rsp.valid = (state == BK_OUT);
  assign rsp.data  = r;

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) c <= cmd;
    r <= r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      sweep    <= '0;
      clr_done <= 1'b0;
    end else begin
      state <= state_next;
      if (!clr_done) begin
        sweep <= (sweep == BW'(BUCKETS - 1)) ? '0 : sweep + 1'b1;
        if (sweep == BW'(BUCKETS - 1)) clr_done <= 1'b1;
      end else if (state == BK_TEVAL) begin
        sweep <= (sweep == BW'(BUCKETS - 1)) ? '0 : sweep + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/ip_fragment_verdict_cache.sv @@
`default_nettype none
// Insert/lookup: after acceptance a command passes through queue, read, compare and out to the result.
// The back end takes no new insert/lookup until the last result is taken, as each does a set memory RMW.
// Tick: every set is read and then written back in turn, one set at a time.
// Reset: after rst the back end clears BUCKETS rows, one a cycle; up to two items
// wait in the front queue meanwhile, config writes are taken at once.
// ----------------------------------------------------------------------------
// ip_fragment_verdict_cache
// Set-associative verdict cache for IP fragments.
// ----------------------------------------------------------------------------
module ip_fragment_verdict_cache #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ifvc_req_if.sink    req,
  ifvc_rsp_if.source  rsp,
  ifvc_cfg_if.sink    cfg
);
  import ifvc_pkg::*;

  logic [7:0]  lifetime;
  logic [31:0] log_mask;
  cmd_t        cmd;
  logic        cmd_valid, cmd_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= LIFETIME_RST;
      log_mask <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LIFETIME: lifetime <= cfg.wdata[7:0];
        REG_LOGMASK:  log_mask <= cfg.wdata;
        default: ;
      endcase
    end
  end

  ifvc_front u_front (
    .clk, .rst, .req, .cmd, .cmd_valid, .cmd_ready
  );

  ifvc_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready,
    .lifetime, .log_mask, .rsp
  );
endmodule
`default_nettype wire

@@ hw/rtl/ifvc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ifvc_checker
// Port-level checks for the fragment verdict cache.
// ----------------------------------------------------------------------------
module ifvc_port_props (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire ifvc_pkg::rsp_t rsp_data
);
  import ifvc_pkg::*;

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.status <= ST_TICK) else $error("bad status");
  a_vout: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_HIT |-> rsp_data.verdict_out == 32'd0)
    else $error("verdict without hit");
  a_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.last_seen |-> rsp_data.status == ST_HIT)
    else $error("last without hit");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped");
endmodule

bind ip_fragment_verdict_cache ifvc_port_props u_chk (
  .clk, .rst, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

@@ bench/ifvc_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifvc_checker
// Watches the item, result and configuration channels of the verdict cache,
// keeps its own copy of the cache contents and checks every result in order.
// ----------------------------------------------------------------------------
module ifvc_checker #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  ifvc_req_if       req,
  ifvc_rsp_if       rsp,
  ifvc_cfg_if       cfg,
  output int        errors,
  output int        pending
);
  import ifvc_pkg::*;

  localparam int ENTRIES = BUCKETS * WAYS;

  logic [7:0]  lifetime;
  logic [31:0] log_mask;
  logic        c_valid [ENTRIES];
  logic [31:0] c_src   [ENTRIES];
  logic [31:0] c_dst   [ENTRIES];
  logic [31:0] c_ipt   [ENTRIES];
  logic [31:0] c_verd  [ENTRIES];
  logic [13:0] c_next  [ENTRIES];
  logic [7:0]  c_ttl   [ENTRIES];
  rsp_t        expected_rsp_q[$];

  task automatic report(input string what);
    $display("%0t ifvc_checker: %s", $realtime, what);
    errors++;
  endtask

  function automatic rsp_t cache_step(input req_t r);
    rsp_t        o;
    logic [31:0] h;
    logic [31:0] ipt;
    logic [13:0] nxt;
    int          base;
    int          hit;
    o = '0;
    o.status = ST_MISS;
    ipt = {r.ident, r.protocol, r.tos};
    h = (32'(r.protocol) + 32'(r.ident) + r.src_addr + r.dst_addr) * 32'd127;
    base = int'(h % BUCKETS) * WAYS;
    nxt = 14'(r.frag_offset) + 14'(r.payload_len >> 3);
    hit = -1;
    for (int w = 0; w < WAYS; w++)
      if (hit < 0 && c_valid[base+w] && c_src[base+w] == r.src_addr &&
          c_dst[base+w] == r.dst_addr && c_ipt[base+w] == ipt)
        hit = base + w;
    case (r.action)
      ACT_INSERT: begin
        if (hit >= 0) begin
          o.status = ST_PRESENT;
        end else begin
          o.status = ST_FULL;
          for (int w = 0; w < WAYS; w++)
            if (o.status == ST_FULL && !c_valid[base+w]) begin
              c_valid[base+w] = 1'b1;
              c_src[base+w]   = r.src_addr;
              c_dst[base+w]   = r.dst_addr;
              c_ipt[base+w]   = ipt;
              c_verd[base+w]  = r.verdict & ~log_mask;
              c_ttl[base+w]   = lifetime;
              c_next[base+w]  = nxt;
              o.status = ST_INSERTED;
            end
        end
      end
      ACT_LOOKUP: begin
        if (hit >= 0) begin
          if (14'(r.frag_offset) == c_next[hit]) begin
            if (!r.more_fragments) begin
              c_ttl[hit] = 8'd1;
              o.last_seen = 1'b1;
            end else begin
              c_next[hit] = nxt;
            end
          end
          o.status = ST_HIT;
          o.verdict_out = c_verd[hit];
        end
      end
      ACT_TICK: begin
        for (int e = 0; e < ENTRIES; e++)
          if (c_valid[e]) begin
            if (c_ttl[e] <= 8'd1) begin
              c_ttl[e] = '0;
              c_valid[e] = 1'b0;
            end else begin
              c_ttl[e] = c_ttl[e] - 8'd1;
            end
          end
        o.status = ST_TICK;
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      lifetime <= LIFETIME_RST;
      log_mask <= '0;
      errors = 0;
      for (int e = 0; e < ENTRIES; e++) c_valid[e] = 1'b0;
      expected_rsp_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_LIFETIME) lifetime <= cfg.wdata[7:0];
        else log_mask <= cfg.wdata;
      end
      if (req.valid && req.ready) expected_rsp_q.push_back(cache_step(req.data));
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.data.status !== want.status)
            report($sformatf("status %0d, want %0d", rsp.data.status, want.status));
          if (rsp.data.verdict_out !== want.verdict_out)
            report($sformatf("verdict_out %h, want %h", rsp.data.verdict_out,
                             want.verdict_out));
          if (rsp.data.last_seen !== want.last_seen)
            report($sformatf("last_seen %b, want %b", rsp.data.last_seen,
                             want.last_seen));
        end
      end
    end
    pending = expected_rsp_q.size();
  end
endmodule
`default_nettype wire

@@ bench/ip_fragment_verdict_cache_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// ip_fragment_verdict_cache_test
// Drives directed and random fragment inserts, lookups and ticks, with
// register changes between phases, random idling on both channels and a
// long result stall; the checker compares every result.
// ----------------------------------------------------------------------------
module ip_fragment_verdict_cache_test;
  import ifvc_pkg::*;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  bit   calm;
  bit   hold_rsp;

  ifvc_req_if req ();
  ifvc_rsp_if rsp ();
  ifvc_cfg_if cfg ();

  ip_fragment_verdict_cache DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));
  ifvc_checker chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                    .errors(errors), .pending(pending));

  // flow pool: a few keys reused so lookups hit and sets fill
  req_t flows[16];
  logic [13:0] flow_off[16];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("ip_fragment_verdict_cache_test: done, errors");
    $finish;
  end

  // result side: random stall, plus one long hold-off
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) rsp.ready <= 1'b0;
      else rsp.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // valid stays high after a beat so items can follow back to back
  task automatic send(input req_t r);
    while (!calm && $urandom_range(99) < 15) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.data  <= r;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg.index <= idx;
    cfg.wdata <= val;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (2 * 256 + 20) @(negedge clk);
  endtask

  function automatic req_t rand_item();
    req_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r.action = 2'($urandom_range(3));
    return r;
  endfunction

  function automatic req_t flow_item(input int f, input logic [1:0] act);
    req_t r;
    r = flows[f];
    r.action = act;
    r.verdict = $urandom;
    r.payload_len = 16'($urandom_range(8, 1500));
    r.more_fragments = 1'($urandom_range(3) != 0);
    r.frag_offset = ($urandom_range(3) != 0) ? flow_off[f][12:0] : 13'($urandom);
    return r;
  endfunction

  task automatic run_random(input int n);
    req_t r;
    int   f;
    int   sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      f = $urandom_range(15);
      if (sel < 30) begin
        r = flow_item(f, ACT_INSERT);
        if (r.more_fragments) flow_off[f] = 14'(r.frag_offset) + 14'(r.payload_len >> 3);
      end else if (sel < 75) begin
        r = flow_item(f, ACT_LOOKUP);
        if (r.frag_offset == flow_off[f][12:0] && r.more_fragments)
          flow_off[f] = 14'(r.frag_offset) + 14'(r.payload_len >> 3);
      end else if (sel < 82) begin
        r = '0;
        r.action = ACT_TICK;
      end else begin
        r = rand_item();
      end
      send(r);
    end
    req.valid <= 1'b0;
  endtask

  initial begin
    req_t r;
    rst = 1'b1;
    calm = 1'b0;
    hold_rsp = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_LIFETIME;
    cfg.wdata = '0;
    // flows 0-7 and flows 8-15 each share one src+dst sum; ident and protocol still vary the bucket
    for (int f = 0; f < 16; f++) begin
      flows[f] = rand_item();
      flows[f].src_addr = 32'($urandom_range(3)) + 32'h1000;
      flows[f].dst_addr = 32'h2000 - flows[f].src_addr + 32'(f / 8);
      flow_off[f] = 14'd0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, full set, in-order last, a tick, a NOP action
    r = '1;
    r.action = ACT_INSERT;
    send(r);
    r.action = ACT_INSERT;
    send(r);
    r.action = ACT_LOOKUP;
    r.frag_offset = 13'h1fff;
    send(r);
    r.frag_offset = 13'h0;
    send(r);
    r = '0;
    r.action = ACT_INSERT;
    r.payload_len = 16'd64;
    send(r);
    r.action = ACT_LOOKUP;
    r.frag_offset = 13'd8;
    r.more_fragments = 1'b1;
    send(r);
    r.frag_offset = 13'd16;
    r.more_fragments = 1'b0;
    send(r);
    for (int i = 0; i < 5; i++) begin
      r = '0;
      r.action = ACT_INSERT;
      r.tos = 8'(i + 1);
      r.verdict = 32'hffff_ffff;
      send(r);
    end
    r = '1;
    r.action = ACT_NOP;
    send(r);
    r = '0;
    r.action = ACT_TICK;
    send(r);
    r.action = ACT_LOOKUP;
    send(r);
    req.valid <= 1'b0;
    drain();

    write_reg(REG_LIFETIME, 32'd1);
    write_reg(REG_LOGMASK, 32'hffff_ffff);
    run_random(150);
    drain();
    write_reg(REG_LIFETIME, 32'd0);
    write_reg(REG_LOGMASK, 32'h0000_00ff);
    run_random(100);
    drain();
    write_reg(REG_LIFETIME, 32'd255);
    write_reg(REG_LOGMASK, 32'd0);
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;
    // stall results long enough that the block backs up
    fork
      begin
        hold_rsp = 1'b1;
        repeat (400) @(negedge clk);
        hold_rsp = 1'b0;
      end
      run_random(60);
    join
    drain();
    write_reg(REG_LIFETIME, 32'($urandom_range(2, 40)));
    write_reg(REG_LOGMASK, $urandom);
    run_random(480);
    drain();

    if (errors == 0) begin
      $display("ip_fragment_verdict_cache_test: done, clean");
    end else begin
      $display("ip_fragment_verdict_cache_test: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
